>>> sv/spbg_pkg.sv
// Shared types and constants of the swap pool byte generator.
// No dependencies; spbg_seq, the top level and the testbench import this package.
`timescale 1ns / 1ps

package spbg_pkg;

  localparam int unsigned PoolDepth = 256;
  localparam int unsigned PtrW      = $clog2(PoolDepth);
  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordW     = 32;
  localparam int unsigned CntW      = 11;

  localparam logic [PtrW-1:0] ReproFirst  = 8'd224;
  localparam logic [PtrW-1:0] ReproSecond = 8'd32;
  localparam logic [CntW-1:0] DiscardMin  = 11'd256;
  localparam logic [CntW-1:0] DiscardMax  = 11'd1024;

  typedef enum logic {
    OP_GENERATE = 1'b0,
    OP_SEED     = 1'b1
  } op_e;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_FILL = 7'b0000010,
    S_RDA  = 7'b0000100,
    S_RDB  = 7'b0001000,
    S_WRA  = 7'b0010000,
    S_WRB  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

  typedef struct packed {
    logic             we;
    logic [PtrW-1:0]  waddr;
    logic [ByteW-1:0] wdata;
    logic [PtrW-1:0]  raddr;
  } mem_req_t;

endpackage

>>> sv/spbg_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module spbg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/spbg_seq.sv
// Sequencer of the swap pool byte generator: pointers, seeding and the
// read/swap/write steps on the pool. Depends on spbg_pkg; drives spbg_ram.
`timescale 1ns / 1ps

module spbg_seq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    repro_mode_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    op_i,
  input  logic [spbg_pkg::WordW-1:0] seed_word_i,
  output spbg_pkg::mem_req_t      mem_req_o,
  input  logic [spbg_pkg::ByteW-1:0] mem_rdata_i,
  output logic                    res_valid_o,
  input  logic                    res_free_i,
  output logic [spbg_pkg::ByteW-1:0] res_byte_o,
  output logic                    res_ns_o
);

  import spbg_pkg::*;

  state_e           state_q, state_d;
  logic [PtrW-1:0]  fp_q, fp_d;
  logic [PtrW-1:0]  sp_q, sp_d;
  logic [PtrW-1:0]  seed_fp_q, seed_fp_d;
  logic [PtrW-1:0]  seed_sp_q, seed_sp_d;
  logic [PtrW-1:0]  fill_cnt_q, fill_cnt_d;
  logic [CntW-1:0]  disc_cnt_q, disc_cnt_d;
  logic             seeded_q, seeded_d;
  logic             gen_q, gen_d;
  logic [ByteW-1:0] a_q, a_d;
  logic [ByteW-1:0] res_q, res_d;
  logic             ns_q, ns_d;

  logic [15:0]      disc_raw;
  logic [CntW-1:0]  disc_clamped;
  logic [PtrW-1:0]  j_ptr;

  // Discard count is {b1, b3} held to the range 256..1024.
  assign disc_raw = {seed_word_i[23:16], seed_word_i[7:0]};
  always_comb begin
    if (disc_raw < 16'(DiscardMin)) begin
      disc_clamped = DiscardMin;
    end else if (disc_raw > 16'(DiscardMax)) begin
      disc_clamped = DiscardMax;
    end else begin
      disc_clamped = disc_raw[CntW-1:0];
    end
  end

  assign j_ptr = sp_q + mem_rdata_i;

  always_comb begin
    state_d    = state_q;
    fp_d       = fp_q;
    sp_d       = sp_q;
    seed_fp_d  = seed_fp_q;
    seed_sp_d  = seed_sp_q;
    fill_cnt_d = fill_cnt_q;
    disc_cnt_d = disc_cnt_q;
    seeded_d   = seeded_q;
    gen_d      = gen_q;
    a_d        = a_q;
    res_d      = res_q;
    ns_d       = ns_q;
    mem_req_o  = '0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (op_e'(op_i) == OP_SEED) begin
            gen_d      = 1'b0;
            fill_cnt_d = '0;
            disc_cnt_d = disc_clamped;
            seed_fp_d  = seed_word_i[31:24];
            seed_sp_d  = seed_word_i[15:8];
            if (repro_mode_i || !seeded_q) begin
              state_d = S_FILL;
            end else begin
              fp_d    = seed_word_i[31:24];
              sp_d    = seed_word_i[15:8];
              state_d = S_RDA;
            end
          end else if (seeded_q) begin
            gen_d   = 1'b1;
            state_d = S_RDA;
          end else if (repro_mode_i) begin
            // Generate before any seed: run a reproducible seed first.
            gen_d      = 1'b1;
            fill_cnt_d = '0;
            state_d    = S_FILL;
          end else begin
            res_d   = '0;
            ns_d    = 1'b1;
            state_d = S_EMIT;
          end
        end
      end
      S_FILL: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = fill_cnt_q;
        mem_req_o.wdata = ~fill_cnt_q;
        fill_cnt_d      = fill_cnt_q + 1'b1;
        if (fill_cnt_q == PtrW'(PoolDepth - 1)) begin
          if (repro_mode_i) begin
            fp_d     = ReproFirst;
            sp_d     = ReproSecond;
            seeded_d = 1'b1;
            state_d  = gen_q ? S_RDA : S_IDLE;
          end else begin
            fp_d    = seed_fp_q;
            sp_d    = seed_sp_q;
            state_d = S_RDA;
          end
        end
      end
      S_RDA: begin
        fp_d            = fp_q + 1'b1;
        mem_req_o.raddr = fp_q + 1'b1;
        state_d         = S_RDB;
      end
      S_RDB: begin
        a_d             = mem_rdata_i;
        sp_d            = j_ptr;
        mem_req_o.raddr = j_ptr;
        state_d         = S_WRA;
      end
      S_WRA: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = fp_q;
        mem_req_o.wdata = mem_rdata_i;
        res_d           = a_q ^ mem_rdata_i;
        ns_d            = 1'b0;
        state_d         = S_WRB;
      end
      S_WRB: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = sp_q;
        mem_req_o.wdata = a_q;
        if (gen_q) begin
          gen_d   = 1'b0;
          state_d = S_EMIT;
        end else begin
          disc_cnt_d = disc_cnt_q - 1'b1;
          if (disc_cnt_q == CntW'(1)) begin
            seeded_d = 1'b1;
            state_d  = S_IDLE;
          end else begin
            state_d = S_RDA;
          end
        end
      end
      S_EMIT: begin
        res_valid_o = 1'b1;
        if (res_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fp_q       <= '0;
      sp_q       <= '0;
      fill_cnt_q <= '0;
      disc_cnt_q <= '0;
      seeded_q   <= 1'b0;
      gen_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      fp_q       <= fp_d;
      sp_q       <= sp_d;
      fill_cnt_q <= fill_cnt_d;
      disc_cnt_q <= disc_cnt_d;
      seeded_q   <= seeded_d;
      gen_q      <= gen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seed_fp_q <= seed_fp_d;
    seed_sp_q <= seed_sp_d;
    a_q       <= a_d;
    res_q     <= res_d;
    ns_q      <= ns_d;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign res_byte_o = res_q;
  assign res_ns_o   = ns_q;

  // The pool is never written while the sequencer waits for an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_req_o.we)
    else $error("pool written while idle");

  // A discard pass always has bytes left to drop when it starts one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDA && !gen_q) |-> (disc_cnt_q != '0))
    else $error("discard pass started with zero count");

  // The last discard leaves the block seeded and idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRB && !gen_q && disc_cnt_q == CntW'(1))
      |=> (seeded_q && state_q == S_IDLE))
    else $error("seed did not complete after last discard");

  // A refused generate never touches the pool or the pointers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && ns_q) |-> (!seeded_q && $stable(fp_q) && $stable(sp_q)))
    else $error("refused generate changed state");

endmodule

>>> sv/swap_pool_byte_generator.sv
// Top level of the swap pool byte generator: configuration register,
// output register, and the sequencer with its pool RAM (spbg_seq, spbg_ram).
`timescale 1ns / 1ps

// An ARC4-style byte generator over a 256-byte pool held in a single-port
// read, single-port write RAM. All work runs one step per cycle through the
// RAM ports, save while a result waits in S_EMIT for the output register,
// so the block takes one item at a time. A generate item that finds the
// block seeded steps through S_RDA, S_RDB, S_WRA and S_WRB (one read of each
// pool entry, one write each) and hands its result over in S_EMIT; the block
// accepts the next item once it is back in S_IDLE. A reproducible seed
// refills the pool; a word seed refills it (only on the first seed) and then
// runs one read/swap/write pass for each of the 256 to 1024 discarded bytes.
// A generate in reproducible mode before any seed first runs that refill.
// The result waits in the output register while the next item is taken in.
module swap_pool_byte_generator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [spbg_pkg::WordW-1:0]  seed_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [spbg_pkg::ByteW-1:0]  rand_byte_o,
  output logic                        not_seeded_o
);

  import spbg_pkg::*;

  logic             repro_q;
  mem_req_t         mem_req;
  logic [ByteW-1:0] mem_rdata;
  logic             res_valid;
  logic             res_free;
  logic [ByteW-1:0] res_byte;
  logic             res_ns;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q;
  logic             out_ns_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repro_q <= 1'b1;
    end else if (cfg_we_i) begin
      repro_q <= cfg_wdata_i;
    end
  end

  spbg_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .repro_mode_i (repro_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .seed_word_i  (seed_word_i),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .res_valid_o  (res_valid),
    .res_free_i   (res_free),
    .res_byte_o   (res_byte),
    .res_ns_o     (res_ns)
  );

  spbg_ram #(
    .Width (ByteW),
    .Depth (PoolDepth)
  ) u_pool (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // The output slot is free when empty or being taken this cycle.
  assign res_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_free) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && res_valid) begin
      out_byte_q <= res_byte;
      out_ns_q   <= res_ns;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign rand_byte_o  = out_byte_q;
  assign not_seeded_o = out_ns_q;

endmodule

>>> tb/sv/tb_swap_pool_byte_generator.sv
// Self-checking testbench for swap_pool_byte_generator: it drives seed and generate
// items, mirrors the byte pool to predict every output byte, and compares field by field.
// Depends on spbg_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_swap_pool_byte_generator;
  import spbg_pkg::*;

  localparam int unsigned SettleCycles = 4500;  // longest word seed plus margin
  localparam int unsigned TailCycles   = 4500;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned PhaseItems   = 300;
  localparam int unsigned MaxReports   = 10;

  typedef enum logic [1:0] {
    CMD_ITEM,
    CMD_CFG,
    CMD_QUIET
  } cmd_kind_e;

  typedef struct {
    cmd_kind_e         kind;
    op_e               op;
    logic [WordW-1:0]  word;
    logic              mode;
    int unsigned       hold;
  } cmd_t;

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             refused;
  } draw_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_wdata = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  op_e              op_sel = OP_GENERATE;
  logic [WordW-1:0] seed_word = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ByteW-1:0] rand_byte;
  logic             not_seeded;

  swap_pool_byte_generator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (op_sel),
    .seed_word_i  (seed_word),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .rand_byte_o  (rand_byte),
    .not_seeded_o (not_seeded)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Mirror of the block's state.
  logic [ByteW-1:0] mirror_pool [PoolDepth];
  logic [PtrW-1:0]  mirror_i = '0;
  logic [PtrW-1:0]  mirror_j = '0;
  bit               mirror_seeded = 1'b0;
  bit               mirror_repro = 1'b1;

  cmd_t        backlog [$];
  draw_t       bytes_due [$];
  int unsigned results_due = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  bit          settled = 1'b0;
  bit          plan_repro = 1'b1;
  longint      budget = 5000;
  longint      cycle_limit = 64'd100_000_000;
  longint      cycle_cnt = 0;

  function automatic logic [ByteW-1:0] swap_draw();
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] b;
    mirror_i = mirror_i + 1'b1;
    a = mirror_pool[mirror_i];
    mirror_j = mirror_j + a;
    b = mirror_pool[mirror_j];
    mirror_pool[mirror_i] = b;
    mirror_pool[mirror_j] = a;
    return a ^ b;
  endfunction

  function automatic void refill_pool();
    for (int k = 0; k < PoolDepth; k++) begin
      mirror_pool[k] = 8'(PoolDepth - 1 - k);
    end
  endfunction

  function automatic void apply_seed(logic [WordW-1:0] word);
    int unsigned count;
    count = {word[23:16], word[7:0]};
    if (mirror_repro) begin
      refill_pool();
      mirror_i = ReproFirst;
      mirror_j = ReproSecond;
    end else begin
      if (!mirror_seeded) refill_pool();
      mirror_i = word[31:24];
      mirror_j = word[15:8];
      if (count < DiscardMin) count = DiscardMin;
      if (count > DiscardMax) count = DiscardMax;
      repeat (count) void'(swap_draw());
    end
    mirror_seeded = 1'b1;
  endfunction

  function automatic void predict_item(op_e op, logic [WordW-1:0] word);
    draw_t d;
    if (op == OP_SEED) begin
      apply_seed(word);
    end else begin
      if (!mirror_seeded && !mirror_repro) begin
        d.value = '0;
        d.refused = 1'b1;
      end else begin
        // A generate before any seed in reproducible mode seeds first.
        if (!mirror_seeded) apply_seed('0);
        d.value = swap_draw();
        d.refused = 1'b0;
      end
      bytes_due.push_back(d);
      results_due++;
    end
  endfunction

  function automatic void push_item(op_e op, logic [WordW-1:0] word);
    cmd_t c;
    c.kind = CMD_ITEM;
    c.op = op;
    c.word = word;
    c.mode = 1'b0;
    c.hold = 0;
    backlog.push_back(c);
    if (op == OP_GENERATE) budget += 120;
    else if (plan_repro) budget += 400;
    else budget += PoolDepth + 4 * DiscardMax + 200;
  endfunction

  function automatic void push_cfg(logic mode);
    cmd_t c;
    c.kind = CMD_CFG;
    c.op = OP_GENERATE;
    c.word = '0;
    c.mode = mode;
    c.hold = 0;
    backlog.push_back(c);
    plan_repro = mode;
    budget += 10;
  endfunction

  function automatic void push_quiet(int unsigned hold);
    cmd_t c;
    c.kind = CMD_QUIET;
    c.op = OP_GENERATE;
    c.word = '0;
    c.mode = 1'b0;
    c.hold = hold;
    backlog.push_back(c);
    budget += hold + 200;
  endfunction

  function automatic void push_random_item();
    logic [WordW-1:0] w;
    w = $urandom();
    if ($urandom_range(0, 99) < 6) begin
      // Word seeds mostly keep the discard count under 1280; a few take the full 16-bit range.
      if (!plan_repro && $urandom_range(0, 9) != 0) begin
        w[23:16] = 8'($urandom_range(0, 4));
      end
      push_item(OP_SEED, w);
    end else begin
      push_item(OP_GENERATE, w);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned pick_stall();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > cycle_limit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Driver: feeds items and register writes from the backlog.
  cmd_t        head;
  op_e         cur_op = OP_GENERATE;
  logic [31:0] cur_word = '0;
  logic        nxt_valid;
  logic        nxt_we;
  int unsigned gap_left = 0;
  int unsigned quiet_cnt = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      nxt_valid = in_valid;
      nxt_we = 1'b0;
      if (in_valid && !in_stall) begin
        predict_item(cur_op, cur_word);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (backlog.size() > 0) begin
          head = backlog[0];
          case (head.kind)
            CMD_ITEM: begin
              void'(backlog.pop_front());
              cur_op = head.op;
              cur_word = head.word;
              op_sel <= head.op;
              seed_word <= head.word;
              nxt_valid = 1'b1;
              gap_left = (cycle_cnt[10:9] == 2'd2) ? 0 : pick_gap();
            end
            CMD_CFG: begin
              void'(backlog.pop_front());
              nxt_we = 1'b1;
              cfg_wdata <= head.mode;
              mirror_repro = head.mode;
            end
            default: begin
              if (results_due == results_seen) begin
                if (quiet_cnt >= head.hold) begin
                  void'(backlog.pop_front());
                  quiet_cnt = 0;
                end else begin
                  quiet_cnt++;
                end
              end
            end
          endcase
        end
      end
      in_valid <= nxt_valid;
      cfg_we <= nxt_we;
      settled <= (backlog.size() == 0) && !nxt_valid && (results_due == results_seen);
    end
  end

  // Receiver stalls, with two long hold-offs while items keep coming.
  int unsigned stall_left = 0;
  int unsigned next_hold_at = 150;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (results_seen >= next_hold_at) begin
        stall_left = LongHold;
        next_hold_at = next_hold_at + 850;
      end
      if (stall_left == 0 && cycle_cnt[9:8] != 2'd3) stall_left = pick_stall();
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: every accepted result must match the oldest predicted byte.
  draw_t got;
  draw_t want;

  function automatic void report(string what, draw_t w, draw_t g);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%s: expected byte %02h flag %0b, got byte %02h flag %0b",
               what, w.value, w.refused, g.value, g.refused);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      got.value = rand_byte;
      got.refused = not_seeded;
      if (bytes_due.size() == 0) begin
        report("result with nothing pending", '0, got);
      end else begin
        want = bytes_due.pop_front();
        if (got.value !== want.value || got.refused !== want.refused) begin
          report("result mismatch", want, got);
        end
      end
    end
  end

  initial begin
    // Word mode straight after reset: generates are refused.
    push_quiet(8);
    push_cfg(1'b0);
    push_item(OP_GENERATE, 32'h0000_0000);
    push_item(OP_GENERATE, 32'hFFFF_FFFF);

    // Reproducible mode, still unseeded: the first generate seeds by itself.
    push_quiet(16);
    push_cfg(1'b1);
    push_item(OP_GENERATE, 32'h0000_0000);
    push_item(OP_GENERATE, 32'h1234_5678);
    push_item(OP_GENERATE, 32'hFFFF_FFFF);
    push_item(OP_SEED, 32'hFFFF_FFFF);
    push_item(OP_GENERATE, 32'h0000_0000);
    push_item(OP_GENERATE, 32'h8000_0001);
    push_item(OP_SEED, 32'h0000_0000);
    push_item(OP_GENERATE, 32'h0000_0000);

    // Word mode after seeding keeps the pool; discard counts at and beyond the clamps.
    push_quiet(SettleCycles);
    push_cfg(1'b0);
    push_item(OP_SEED, 32'h0000_0000);
    push_item(OP_GENERATE, 32'h0000_0000);
    push_item(OP_GENERATE, 32'hFFFF_FFFF);
    push_item(OP_SEED, 32'hFFFF_FFFF);
    push_item(OP_GENERATE, 32'h0000_0000);
    push_item(OP_SEED, 32'hA504_5A00);
    push_item(OP_GENERATE, 32'h0000_0000);
    push_item(OP_SEED, 32'h3C00_C3FF);
    push_item(OP_GENERATE, 32'h0000_0000);
    push_item(OP_SEED, 32'h0101_0000);
    push_item(OP_GENERATE, 32'h0000_0000);

    for (int ph = 0; ph < 6; ph++) begin
      push_quiet(SettleCycles);
      push_cfg((ph % 2) == 0);
      for (int n = 0; n < PhaseItems; n++) begin
        // Halfway through, the sender waits for every pending byte.
        if (n == PhaseItems / 2) push_quiet(0);
        push_random_item();
      end
    end
    cycle_limit = 4 * budget;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (!settled);
    repeat (TailCycles) @(posedge clk_i);
    if (bytes_due.size() != 0) mismatches += bytes_due.size();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
